// ===== rtl/poi_pkg.sv =====
package poi_pkg;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL,
    ST_HALF,
    ST_OUT
  } state_e;

  localparam int unsigned ATAN_LEN = 24;
  localparam int unsigned ATAN_IDX_W = 5;

  // CORDIC limit gain 0.6072529350 in Q2.30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  // 2^32 / (2*pi), rounded
  localparam logic signed [31:0] RAD_TO_BAM = 32'sd683565276;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/poi_if.sv =====
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic        [15:0] time_step;
  logic signed [15:0] vel_forward;
  logic signed [15:0] vel_lateral;
  logic signed [15:0] yaw_rate;

  modport source (output valid, time_step, vel_forward, vel_lateral, yaw_rate,
                  input ready);
  modport sink (input valid, time_step, vel_forward, vel_lateral, yaw_rate,
                output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading_angle;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
                output ready);
endinterface

// ===== rtl/poi_cordic.sv =====
module poi_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic        [31:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import poi_pkg::*;

  localparam int unsigned CntW = $clog2(STEPS);
  localparam logic [CntW-1:0] LastCnt = CntW'(STEPS - 1);

  logic                  run_q, fin_q, done_q, flip_q;
  logic [CntW-1:0]       cnt_q;
  logic signed [33:0]    x_q, y_q, z_q;
  logic signed [31:0]    sin_q, cos_q;

  logic [31:0]           wrap_sum, a_red;
  logic                  flip;
  logic signed [33:0]    x_sh, y_sh, atan_s;
  logic                  z_pos;

  // half-turn flip brings the angle into [-1/4, +1/4) turn
  assign wrap_sum = angle_i + 32'h4000_0000;
  assign flip     = wrap_sum[31];
  assign a_red    = flip ? (angle_i ^ 32'h8000_0000) : angle_i;

  assign x_sh   = x_q >>> cnt_q;
  assign y_sh   = y_q >>> cnt_q;
  assign atan_s = $signed({2'b00, atan_bam(ATAN_IDX_W'(cnt_q))});
  assign z_pos  = !z_q[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == LastCnt) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= $signed({{2{a_red[31]}}, a_red});
      flip_q <= flip;
    end else if (run_q) begin
      if (z_pos) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_s;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_s;
      end
    end
    if (fin_q) begin
      cos_q <= flip_q ? 32'(-x_q) : x_q[31:0];
      sin_q <= flip_q ? 32'(-y_q) : y_q[31:0];
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

// ===== rtl/planar_odometry_integrator.sv =====
// Planar dead-reckoning odometry. Each request carries a time step (Q0.16 s)
// and body velocities vx, vy (Q4.12 m/s) and yaw rate (Q4.12 rad/s). The
// velocity is rotated into the world frame by the stored heading, scaled by
// the time step and added to x/y (Q16.16, saturating); yaw rate times time
// step then advances the 16-bit binary heading, which wraps. Each request
// gives one result: position, new heading and a yaw-only quaternion
// (z = sin, w = cos of half the heading, Q1.14). Since the heading wraps,
// the quaternion may be the negation of one from an unwrapped heading;
// quat_z is the sine of an angle in [0, pi). Timing: one request at a time.
// A request passes through acceptance, two passes through one shared CORDIC
// rotator (S = min(CORDIC_STEPS, 24) iterations each), an 11-step sequence on
// one 34x32 multiplier and the load of the output register. The result sits
// in an output register; the load waits while an earlier result is still
// unread. in_i.ready is high only while the sequencer is idle.
module planar_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  poi_in_if.sink    in_i,
  poi_out_if.source out_o
);
  import poi_pkg::*;

  localparam int unsigned EffSteps = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  // multiplier sequence; each step issues one product and consumes the last
  localparam logic [3:0] S_VF    = 4'd0;   // vf*dt
  localparam logic [3:0] S_VL    = 4'd1;   // vl*dt, keep vf*dt
  localparam logic [3:0] S_WZ    = 4'd2;   // wz*dt, keep vl*dt
  localparam logic [3:0] S_HDG   = 4'd3;   // (wz*dt)*rad_to_bam
  localparam logic [3:0] S_HRND  = 4'd4;   // round heading step, issue pf*cos
  localparam logic [3:0] S_XC    = 4'd5;   // heading add, issue pl*sin
  localparam logic [3:0] S_XS    = 4'd6;   // x sum, issue pf*sin
  localparam logic [3:0] S_XRND  = 4'd7;   // round x step, issue pl*cos
  localparam logic [3:0] S_XUPD  = 4'd8;   // x saturating add, y sum
  localparam logic [3:0] S_YRND  = 4'd9;   // round y step
  localparam logic [3:0] S_YUPD  = 4'd10;  // y saturating add, start half-angle pass

  state_e state_q, state_d;
  logic [3:0] step_q, step_d;

  // latched request
  logic        [15:0] dt_q;
  logic signed [15:0] vf_q, vl_q, wz_q;

  // datapath
  logic signed [32:0] pf_q, pl_q;     // velocity * dt
  logic signed [65:0] mul_q, acc_q;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic        [15:0] hstep_q;
  logic signed [23:0] dpos_q;
  logic signed [31:0] x_q, y_q;
  logic        [15:0] heading_q;

  logic [59:0]        hsum;
  logic signed [65:0] rsum;

  // shared CORDIC
  logic               cor_start, cor_done;
  logic        [31:0] cor_angle;
  logic signed [31:0] cor_sin, cor_cos;

  // output register
  logic               out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic        [15:0] hdg_out_q;
  logic signed [15:0] qz_q, qw_q;
  logic               accept, load_out;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [23:0] d);
    logic signed [32:0] s;
    s = 33'(acc) + 33'(d);
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return s[31:0];
  endfunction

  // Q2.30 -> Q1.14, round half up, clamp to +-1.0
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [16:0] r;
    t = 33'(v) + 33'sd32768;
    r = t[32:16];
    if (r > 17'sd16384) return 16'sd16384;
    if (r < -17'sd16384) return -16'sd16384;
    return r[15:0];
  endfunction

  poi_cordic #(
    .STEPS (EffSteps)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign load_out   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  // first pass uses the old heading, second the new heading at half angle
  assign cor_start = accept || (state_q == ST_MUL && step_q == S_YUPD);
  assign cor_angle = (state_q == ST_IDLE) ? {heading_q, 16'h0000}
                                          : {1'b0, heading_q, 15'h0000};

  // sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_ROT;
      end
      ST_ROT: begin
        if (cor_done) begin
          state_d = ST_MUL;
          step_d  = S_VF;
        end
      end
      ST_MUL: begin
        step_d = step_q + 4'd1;
        if (step_q == S_YUPD) state_d = ST_HALF;
      end
      ST_HALF: begin
        if (cor_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= S_VF;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      unique case (step_q)
        S_VF: begin
          mul_a = 34'(vf_q);
          mul_b = $signed({16'h0000, dt_q});
        end
        S_VL: begin
          mul_a = 34'(vl_q);
          mul_b = $signed({16'h0000, dt_q});
        end
        S_WZ: begin
          mul_a = 34'(wz_q);
          mul_b = $signed({16'h0000, dt_q});
        end
        S_HDG: begin
          mul_a = mul_q[33:0];
          mul_b = RAD_TO_BAM;
        end
        S_HRND: begin
          mul_a = 34'(pf_q);
          mul_b = cor_cos;
        end
        S_XC: begin
          mul_a = 34'(pl_q);
          mul_b = cor_sin;
        end
        S_XS: begin
          mul_a = 34'(pf_q);
          mul_b = cor_sin;
        end
        S_XRND: begin
          mul_a = 34'(pl_q);
          mul_b = cor_cos;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // heading step: round half up by 2^43, keep bits [59:44] (wraps mod 2^16)
  assign hsum = mul_q[59:0] + 60'h800_0000_0000;
  // position step: round half up by 2^41, shift right 42
  assign rsum = acc_q + 66'sh200_0000_0000;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q <= in_i.time_step;
      vf_q <= in_i.vel_forward;
      vl_q <= in_i.vel_lateral;
      wz_q <= in_i.yaw_rate;
    end
    if (state_q == ST_MUL) begin
      mul_q <= 66'(mul_a) * 66'(mul_b);
      unique case (step_q)
        S_VL:   pf_q    <= mul_q[32:0];
        S_WZ:   pl_q    <= mul_q[32:0];
        S_HRND: hstep_q <= hsum[59:44];
        S_XC:   acc_q   <= mul_q;            // pf*cos
        S_XS:   acc_q   <= acc_q - mul_q;    // - pl*sin
        S_XRND: begin
          dpos_q <= rsum[65:42];
          acc_q  <= mul_q;                   // pf*sin
        end
        S_XUPD: acc_q   <= acc_q + mul_q;    // + pl*cos
        S_YRND: dpos_q  <= rsum[65:42];
        default: ;
      endcase
    end
    if (load_out) begin
      pos_x_q   <= x_q;
      pos_y_q   <= y_q;
      hdg_out_q <= heading_q;
      qz_q      <= to_q14(cor_sin);
      qw_q      <= to_q14(cor_cos);
    end
  end

  // pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q       <= '0;
      y_q       <= '0;
      heading_q <= '0;
    end else if (state_q == ST_MUL) begin
      if (step_q == S_XC)   heading_q <= heading_q + hstep_q;
      if (step_q == S_XUPD) x_q <= sat_add(x_q, dpos_q);
      if (step_q == S_YUPD) y_q <= sat_add(y_q, dpos_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = pos_x_q;
  assign out_o.pos_y         = pos_y_q;
  assign out_o.heading_angle = hdg_out_q;
  assign out_o.quat_z        = qz_q;
  assign out_o.quat_w        = qw_q;

`ifndef SYNTHESIS
  // CORDIC finishes only while the sequencer waits for it
  a_cordic_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == ST_ROT || state_q == ST_HALF))
    else $error("CORDIC done outside a rotation wait");

  // a fresh result shows the pose state it was taken from
  a_result_matches_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_o.pos_x == x_q && out_o.pos_y == y_q &&
                            out_o.heading_angle == heading_q))
    else $error("result does not match pose state");

  // quaternion components stay within +-1.0 in Q1.14
  a_quat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.quat_w <= 16'sd16384 && out_o.quat_w >= -16'sd16384 &&
                     out_o.quat_z <= 16'sd16384 && out_o.quat_z >= -16'sd16384))
    else $error("quaternion component out of range");
`endif

endmodule
